@@ rtl/dual_exponential_synapse_defines.svh @@
// Assertion macros for the dual-exponential synapse.
`ifndef DUAL_EXPONENTIAL_SYNAPSE_DEFINES_SVH
`define DUAL_EXPONENTIAL_SYNAPSE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define DES_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DES_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dexp_syn_pkg.sv @@
// Constants and types for the dual-exponential synapse.
`timescale 1ns / 1ps

package dexp_syn_pkg;

  localparam int unsigned STATE_WIDTH_DEF = 32;

  localparam int unsigned IO_W    = 16;
  localparam int unsigned RES_W   = 32;
  localparam int unsigned INC_W   = 29;
  localparam int unsigned CFG_AW  = 5;
  localparam int unsigned CFG_DW  = 32;

  localparam int unsigned SPIKE_SHIFT = 4;
  localparam int unsigned COEF_SHIFT  = 16;
  localparam int unsigned GAIN_SHIFT  = 8;

  localparam logic [IO_W-1:0] NORM_RESET = 16'd4096;

  typedef enum logic [2:0] {
    REG_NORM = 3'd0,
    REG_RISE = 3'd1,
    REG_FALL = 3'd2,
    REG_GMAX = 3'd3,
    REG_EREV = 3'd4
  } reg_idx_t;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCALE1 = 9'b000000010,
    S_SCALE2 = 9'b000000100,
    S_SCALE3 = 9'b000001000,
    S_DIFF   = 9'b000010000,
    S_GMUL   = 9'b000100000,
    S_GSAT   = 9'b001000000,
    S_IMUL   = 9'b010000000,
    S_ISAT   = 9'b100000000
  } state_t;

endpackage

@@ rtl/dual_exponential_synapse.sv @@
// Dual-exponential conductance synapse with one shared multiplier under a sequencer.
//
// Input channel (in_valid / in_stall): in_command 0 adds weight times norm_factor to both
// rise and decay states, 1 decays them by one time step. Each transaction yields exactly
// one result transaction (out_valid / out_stall) carrying conductance, current and a
// saturation flag. The user writes registers via the APB-style port only while idle;
// the block does not enforce this. A single 16-bit by max(state width + 1, 32)-bit
// multiplier does every product in turn: spike items need 3 products, tick items need 4.
// The input is stalled until an item's result is loaded into the output register.
// A finished result sits in the output register; the next transaction is accepted and
// worked on meanwhile, and only its final step waits while out_stall holds the previous
// result. Synchronous reset clears both states, the registers to their reset values
// (norm_factor 1.0, others zero) and drops any pending result.
`timescale 1ns / 1ps
`include "dual_exponential_synapse_defines.svh"

module dual_exponential_synapse #(
  parameter int unsigned STATE_WIDTH = dexp_syn_pkg::STATE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,

  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_command,
  input  logic signed [dexp_syn_pkg::IO_W-1:0]   in_weight,
  input  logic signed [dexp_syn_pkg::IO_W-1:0]   in_membrane_voltage,

  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [dexp_syn_pkg::RES_W-1:0]  out_conductance,
  output logic signed [dexp_syn_pkg::RES_W-1:0]  out_current,
  output logic                                   out_saturated,

  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [dexp_syn_pkg::CFG_AW-1:0]        paddr,
  input  logic [dexp_syn_pkg::CFG_DW-1:0]        pwdata,
  output logic [dexp_syn_pkg::CFG_DW-1:0]        prdata,
  output logic                                   pready
);

  localparam int unsigned SW    = STATE_WIDTH;
  localparam int unsigned IO_W  = dexp_syn_pkg::IO_W;
  localparam int unsigned RES_W = dexp_syn_pkg::RES_W;
  localparam int unsigned INC_W = dexp_syn_pkg::INC_W;
  localparam int unsigned MA    = (SW + 1 > RES_W) ? SW + 1 : RES_W;
  localparam int unsigned PW    = MA + IO_W;
  localparam int unsigned RW    = PW + 1;
  localparam int unsigned SUMW  = ((SW > INC_W) ? SW : INC_W) + 1;

  localparam logic signed [SUMW-1:0] ST_MAX  = SUMW'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [SUMW-1:0] ST_MIN  = ~ST_MAX;
  localparam logic [RW-1:0]          POS_LIM = RW'({1'b0, {(RES_W-1){1'b1}}});
  localparam logic [RW-1:0]          NEG_LIM = POS_LIM + RW'(1);

  dexp_syn_pkg::state_t state_r, state_nxt;

  logic [IO_W-1:0]          norm_factor_r, rise_decay_r, fall_decay_r, peak_cond_r;
  logic signed [IO_W-1:0]   rev_pot_r;

  logic                     cmd_r;
  logic signed [IO_W-1:0]   weight_r, volt_r;
  logic signed [SW-1:0]     rise_r, decay_r;
  logic signed [SW:0]       diff_r;
  logic signed [IO_W:0]     drive_r;
  logic signed [RES_W-1:0]  g_r;
  logic [PW-1:0]            prod_r;
  logic                     sat_r;

  logic                     out_valid_r, out_sat_r;
  logic signed [RES_W-1:0]  out_cond_r, out_cur_r;

  logic                     in_acc, cfg_wr, out_load;
  logic [IO_W-1:0]          w_mag;
  logic [SW-1:0]            a_mag, b_mag;
  logic [SW:0]              diff_mag;
  logic [RES_W-1:0]         g_mag;
  logic [IO_W:0]            drive_mag;
  logic [MA-1:0]            mul_a;
  logic [IO_W-1:0]          mul_b;
  logic [PW-1:0]            mul_p;

  logic                     spike_rnd, coef_rnd;
  logic [RW-1:0]            rnd_half, rnd_add, rnd;

  logic [INC_W-2:0]         inc_mag;
  logic signed [SUMW-1:0]   inc_ext, inc, sum_a, sum_b;
  logic signed [SW-1:0]     clip_a, clip_b;
  logic                     ovf_a, ovf_b;

  logic [SW-1:0]            t_mag;
  logic                     coef_sign;
  logic signed [SW-1:0]     coef_val;

  logic                     cur_neg, clip_neg, clip_flag;
  logic signed [RES_W-1:0]  clip_val;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != dexp_syn_pkg::S_IDLE);
  assign out_load = (state_r == dexp_syn_pkg::S_ISAT) && (!out_valid_r || !out_stall);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_conductance = out_cond_r;
  assign out_current     = out_cur_r;
  assign out_saturated   = out_sat_r;

  // magnitudes
  assign w_mag     = weight_r[IO_W-1] ? (~weight_r + 1'b1) : weight_r;
  assign a_mag     = rise_r[SW-1] ? (~rise_r + 1'b1) : rise_r;
  assign b_mag     = decay_r[SW-1] ? (~decay_r + 1'b1) : decay_r;
  assign diff_mag  = diff_r[SW] ? (~diff_r + 1'b1) : diff_r;
  assign g_mag     = g_r[RES_W-1] ? (~g_r + 1'b1) : g_r;
  assign drive_mag = drive_r[IO_W] ? (~drive_r + 1'b1) : drive_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      dexp_syn_pkg::S_SCALE1: begin
        if (cmd_r) begin
          mul_a = MA'(a_mag);
          mul_b = rise_decay_r;
        end else begin
          mul_a = MA'(w_mag);
          mul_b = norm_factor_r;
        end
      end
      dexp_syn_pkg::S_SCALE2: begin
        mul_a = MA'(b_mag);
        mul_b = fall_decay_r;
      end
      dexp_syn_pkg::S_GMUL: begin
        mul_a = MA'(diff_mag);
        mul_b = peak_cond_r;
      end
      dexp_syn_pkg::S_IMUL: begin
        mul_a = MA'(g_mag);
        mul_b = drive_mag[IO_W-1:0];
      end
      dexp_syn_pkg::S_IDLE, dexp_syn_pkg::S_SCALE3, dexp_syn_pkg::S_DIFF,
      dexp_syn_pkg::S_GSAT, dexp_syn_pkg::S_ISAT: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // round to nearest, ties away from zero, on the product magnitude
  assign spike_rnd = (state_r == dexp_syn_pkg::S_SCALE2) && !cmd_r;
  assign coef_rnd  = ((state_r == dexp_syn_pkg::S_SCALE2) && cmd_r) ||
                     (state_r == dexp_syn_pkg::S_SCALE3);

  always_comb begin
    priority if (spike_rnd) begin
      rnd_half = RW'(1) << (dexp_syn_pkg::SPIKE_SHIFT - 1);
    end else if (coef_rnd) begin
      rnd_half = RW'(1) << (dexp_syn_pkg::COEF_SHIFT - 1);
    end else begin
      rnd_half = RW'(1) << (dexp_syn_pkg::GAIN_SHIFT - 1);
    end
    rnd_add = {1'b0, prod_r} + rnd_half;
    priority if (spike_rnd) begin
      rnd = rnd_add >> dexp_syn_pkg::SPIKE_SHIFT;
    end else if (coef_rnd) begin
      rnd = rnd_add >> dexp_syn_pkg::COEF_SHIFT;
    end else begin
      rnd = rnd_add >> dexp_syn_pkg::GAIN_SHIFT;
    end
  end

  // spike increment and state clipping
  assign inc_mag = rnd[INC_W-2:0];
  assign inc_ext = $signed({{(SUMW-INC_W+1){1'b0}}, inc_mag});
  assign inc     = weight_r[IO_W-1] ? -inc_ext : inc_ext;
  assign sum_a   = SUMW'(rise_r) + inc;
  assign sum_b   = SUMW'(decay_r) + inc;

  always_comb begin
    ovf_a = 1'b0;
    ovf_b = 1'b0;
    priority if (sum_a > ST_MAX) begin
      clip_a = ST_MAX[SW-1:0];
      ovf_a  = 1'b1;
    end else if (sum_a < ST_MIN) begin
      clip_a = ST_MIN[SW-1:0];
      ovf_a  = 1'b1;
    end else begin
      clip_a = sum_a[SW-1:0];
    end
    priority if (sum_b > ST_MAX) begin
      clip_b = ST_MAX[SW-1:0];
      ovf_b  = 1'b1;
    end else if (sum_b < ST_MIN) begin
      clip_b = ST_MIN[SW-1:0];
      ovf_b  = 1'b1;
    end else begin
      clip_b = sum_b[SW-1:0];
    end
  end

  // decayed state, sign restored
  assign t_mag     = rnd[SW-1:0];
  assign coef_sign = (state_r == dexp_syn_pkg::S_SCALE3) ? decay_r[SW-1] : rise_r[SW-1];
  assign coef_val  = coef_sign ? (~t_mag + 1'b1) : t_mag;

  // 32-bit result clipping, shared by conductance and current
  assign cur_neg  = ~(g_r[RES_W-1] ^ drive_r[IO_W]);
  assign clip_neg = (state_r == dexp_syn_pkg::S_ISAT) ? cur_neg : diff_r[SW];

  always_comb begin
    clip_flag = 1'b0;
    if (clip_neg) begin
      if (rnd > NEG_LIM) begin
        clip_val  = {1'b1, {(RES_W-1){1'b0}}};
        clip_flag = 1'b1;
      end else begin
        clip_val  = -rnd[RES_W-1:0];
      end
    end else begin
      if (rnd > POS_LIM) begin
        clip_val  = {1'b0, {(RES_W-1){1'b1}}};
        clip_flag = 1'b1;
      end else begin
        clip_val  = rnd[RES_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dexp_syn_pkg::S_IDLE:   if (in_acc) state_nxt = dexp_syn_pkg::S_SCALE1;
      dexp_syn_pkg::S_SCALE1: state_nxt = dexp_syn_pkg::S_SCALE2;
      dexp_syn_pkg::S_SCALE2: begin
        state_nxt = cmd_r ? dexp_syn_pkg::S_SCALE3 : dexp_syn_pkg::S_DIFF;
      end
      dexp_syn_pkg::S_SCALE3: state_nxt = dexp_syn_pkg::S_DIFF;
      dexp_syn_pkg::S_DIFF:   state_nxt = dexp_syn_pkg::S_GMUL;
      dexp_syn_pkg::S_GMUL:   state_nxt = dexp_syn_pkg::S_GSAT;
      dexp_syn_pkg::S_GSAT:   state_nxt = dexp_syn_pkg::S_IMUL;
      dexp_syn_pkg::S_IMUL:   state_nxt = dexp_syn_pkg::S_ISAT;
      dexp_syn_pkg::S_ISAT:   if (out_load) state_nxt = dexp_syn_pkg::S_IDLE;
      default:                state_nxt = dexp_syn_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    unique case (dexp_syn_pkg::reg_idx_t'(paddr[4:2]))
      dexp_syn_pkg::REG_NORM: prdata = {16'd0, norm_factor_r};
      dexp_syn_pkg::REG_RISE: prdata = {16'd0, rise_decay_r};
      dexp_syn_pkg::REG_FALL: prdata = {16'd0, fall_decay_r};
      dexp_syn_pkg::REG_GMAX: prdata = {16'd0, peak_cond_r};
      dexp_syn_pkg::REG_EREV: prdata = {{16{rev_pot_r[IO_W-1]}}, rev_pot_r};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= dexp_syn_pkg::S_IDLE;
      norm_factor_r <= dexp_syn_pkg::NORM_RESET;
      rise_decay_r  <= '0;
      fall_decay_r  <= '0;
      peak_cond_r   <= '0;
      rev_pot_r     <= '0;
      rise_r        <= '0;
      decay_r       <= '0;
      sat_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        unique case (dexp_syn_pkg::reg_idx_t'(paddr[4:2]))
          dexp_syn_pkg::REG_NORM: norm_factor_r <= pwdata[IO_W-1:0];
          dexp_syn_pkg::REG_RISE: rise_decay_r  <= pwdata[IO_W-1:0];
          dexp_syn_pkg::REG_FALL: fall_decay_r  <= pwdata[IO_W-1:0];
          dexp_syn_pkg::REG_GMAX: peak_cond_r   <= pwdata[IO_W-1:0];
          dexp_syn_pkg::REG_EREV: rev_pot_r     <= pwdata[IO_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        sat_r <= 1'b0;
      end else if (spike_rnd) begin
        rise_r  <= clip_a;
        decay_r <= clip_b;
        sat_r   <= sat_r | ovf_a | ovf_b;
      end else if ((state_r == dexp_syn_pkg::S_SCALE2) && cmd_r) begin
        rise_r  <= coef_val;
      end else if (state_r == dexp_syn_pkg::S_SCALE3) begin
        decay_r <= coef_val;
      end else if (state_r == dexp_syn_pkg::S_GSAT) begin
        sat_r   <= sat_r | clip_flag;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_command;
      weight_r <= in_weight;
      volt_r   <= in_membrane_voltage;
    end
    if ((state_r == dexp_syn_pkg::S_SCALE1) || (state_r == dexp_syn_pkg::S_SCALE2) ||
        (state_r == dexp_syn_pkg::S_GMUL) || (state_r == dexp_syn_pkg::S_IMUL)) begin
      prod_r <= mul_p;
    end
    if (state_r == dexp_syn_pkg::S_DIFF) begin
      diff_r  <= {decay_r[SW-1], decay_r} - {rise_r[SW-1], rise_r};
      drive_r <= {volt_r[IO_W-1], volt_r} - {rev_pot_r[IO_W-1], rev_pot_r};
    end
    if (state_r == dexp_syn_pkg::S_GSAT) begin
      g_r <= clip_val;
    end
    if (out_load) begin
      out_cond_r <= g_r;
      out_cur_r  <= clip_val;
      out_sat_r  <= sat_r | clip_flag;
    end
  end

  `DES_ASSERT_NXT(a_accept_starts, in_acc, state_r == dexp_syn_pkg::S_SCALE1, "start missed")
  `DES_ASSERT_IMP(a_result_source, $rose(out_valid_r), $past(out_load), "stray result")
  `DES_ASSERT_IMP(a_tick_no_clip, cmd_r && (state_r == dexp_syn_pkg::S_DIFF), !sat_r, "tick clip")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the dual-exponential conductance synapse.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned IO_W   = dexp_syn_pkg::IO_W;
  localparam int unsigned RES_W  = dexp_syn_pkg::RES_W;
  localparam int unsigned CFG_AW = dexp_syn_pkg::CFG_AW;
  localparam int unsigned CFG_DW = dexp_syn_pkg::CFG_DW;

  localparam logic CMD_SPIKE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;
  localparam logic [2:0] SPARE_SLOT = 3'(dexp_syn_pkg::REG_EREV) + 3'd1;
  localparam logic signed [IO_W-1:0] FIELD_MAX = 16'sh7FFF;
  localparam logic signed [IO_W-1:0] FIELD_MIN = 16'sh8000;
  localparam int STATE_BITS     = dexp_syn_pkg::STATE_WIDTH_DEF;
  localparam int PHASE_EVENTS   = 175;
  localparam int HOLDOFF_CYCLES = 500;
  localparam int QUIET_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int PRINT_LIMIT    = 40;

  typedef longint unsigned u64_t;

  typedef struct {
    logic                   command;
    logic signed [IO_W-1:0] weight;
    logic signed [IO_W-1:0] volt;
  } syn_event_t;

  typedef struct {
    logic [RES_W-1:0] conductance;
    logic [RES_W-1:0] current;
    logic             saturated;
  } syn_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_command = 1'b0;
  logic signed [IO_W-1:0] in_weight = '0;
  logic signed [IO_W-1:0] in_membrane_voltage = '0;
  logic out_stall = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  wire in_stall;
  wire out_valid;
  wire signed [RES_W-1:0] out_conductance;
  wire signed [RES_W-1:0] out_current;
  wire out_saturated;
  wire [CFG_DW-1:0] prdata;
  wire pready;

  syn_event_t  queued_events[$];
  syn_result_t predicted_outputs[$];
  syn_event_t  on_offer;

  longint rise_q = 0;
  longint decay_q = 0;
  u64_t   norm_cfg = u64_t'(dexp_syn_pkg::NORM_RESET);
  u64_t   rise_cfg = 0;
  u64_t   fall_cfg = 0;
  u64_t   gain_cfg = 0;
  longint erev_cfg = 0;

  int mismatches = 0;
  int spikes_sent = 0;
  int ticks_sent = 0;
  int saturated_seen = 0;
  int reg_writes = 0;
  int events_queued = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_requests = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;
  int quiet_cycles = 0;

  dual_exponential_synapse u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_weight(in_weight), .in_membrane_voltage(in_membrane_voltage),
    .out_valid(out_valid), .out_stall(out_stall), .out_conductance(out_conductance),
    .out_current(out_current), .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic u64_t magnitude(longint x);
    return (x < 0) ? u64_t'(-x) : u64_t'(x);
  endfunction

  function automatic u64_t round_shift(u64_t m, int s);
    return (m + (u64_t'(1) << (s - 1))) >> s;
  endfunction

  function automatic longint clip_signed(bit neg, u64_t m, int bits, inout bit sat);
    u64_t lim;
    lim = u64_t'(1) << (bits - 1);
    if (neg) begin
      if (m > lim) begin
        m = lim;
        sat = 1'b1;
      end
      return -$signed(m);
    end
    if (m > lim - 1) begin
      m = lim - 1;
      sat = 1'b1;
    end
    return $signed(m);
  endfunction

  function automatic longint decay_by(longint x, u64_t coef);
    u64_t m;
    m = round_shift(magnitude(x) * coef, dexp_syn_pkg::COEF_SHIFT);
    return (x < 0) ? -$signed(m) : $signed(m);
  endfunction

  function automatic syn_result_t predict_synapse(syn_event_t ev);
    syn_result_t res;
    bit sat;
    u64_t m;
    longint inc, diff, drive, g, cur;
    sat = 1'b0;
    if (ev.command == CMD_SPIKE) begin
      m = round_shift(magnitude(longint'(ev.weight)) * norm_cfg, dexp_syn_pkg::SPIKE_SHIFT);
      inc = (ev.weight < 0) ? -$signed(m) : $signed(m);
      rise_q = clip_signed((rise_q + inc) < 0, magnitude(rise_q + inc), STATE_BITS, sat);
      decay_q = clip_signed((decay_q + inc) < 0, magnitude(decay_q + inc), STATE_BITS, sat);
    end else begin
      rise_q = decay_by(rise_q, rise_cfg);
      decay_q = decay_by(decay_q, fall_cfg);
    end
    diff = decay_q - rise_q;
    g = clip_signed(diff < 0,
                    round_shift(magnitude(diff) * gain_cfg, dexp_syn_pkg::GAIN_SHIFT),
                    RES_W, sat);
    drive = longint'(ev.volt) - erev_cfg;
    cur = clip_signed((g < 0) == (drive < 0),
                      round_shift(magnitude(g) * magnitude(drive), dexp_syn_pkg::GAIN_SHIFT),
                      RES_W, sat);
    res.conductance = g[RES_W-1:0];
    res.current = cur[RES_W-1:0];
    res.saturated = sat;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : event_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_outputs.push_back(predict_synapse(on_offer));
        if (on_offer.command == CMD_SPIKE) spikes_sent++;
        else ticks_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (queued_events.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          on_offer = queued_events.pop_front();
          in_valid <= 1'b1;
          in_command <= on_offer.command;
          in_weight <= on_offer.weight;
          in_membrane_voltage <= on_offer.volt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    syn_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (out_saturated) saturated_seen++;
      if (predicted_outputs.size() == 0) begin
        report_mismatch("result transaction with nothing predicted");
      end else begin
        want = predicted_outputs.pop_front();
        if (out_conductance !== want.conductance)
          report_mismatch($sformatf("conductance %h, predicted %h",
                                    out_conductance, want.conductance));
        if (out_current !== want.current)
          report_mismatch($sformatf("current %h, predicted %h", out_current, want.current));
        if (out_saturated !== want.saturated)
          report_mismatch($sformatf("saturated %b, predicted %b",
                                    out_saturated, want.saturated));
      end
    end
  end

  always @(posedge clk) begin : stall_driver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holdoff_seen != holdoff_requests) begin
      holdoff_seen = holdoff_requests;
      holdoff_left = HOLDOFF_CYCLES;
      out_stall <= 1'b1;
    end else if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [2:0] slot, logic [IO_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {slot, 2'b00};
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (slot)
      dexp_syn_pkg::REG_NORM: norm_cfg = u64_t'(value);
      dexp_syn_pkg::REG_RISE: rise_cfg = u64_t'(value);
      dexp_syn_pkg::REG_FALL: fall_cfg = u64_t'(value);
      dexp_syn_pkg::REG_GMAX: gain_cfg = u64_t'(value);
      dexp_syn_pkg::REG_EREV: erev_cfg = longint'($signed(value));
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic apply_setting(logic [IO_W-1:0] norm, logic [IO_W-1:0] rise,
                               logic [IO_W-1:0] fall, logic [IO_W-1:0] gain,
                               logic [IO_W-1:0] erev);
    write_reg(dexp_syn_pkg::REG_NORM, norm);
    write_reg(dexp_syn_pkg::REG_RISE, rise);
    write_reg(dexp_syn_pkg::REG_FALL, fall);
    write_reg(dexp_syn_pkg::REG_GMAX, gain);
    write_reg(dexp_syn_pkg::REG_EREV, erev);
  endtask

  task automatic wait_until_idle();
    while (queued_events.size() != 0 || in_valid || predicted_outputs.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_event(logic cmd, logic signed [IO_W-1:0] w, logic signed [IO_W-1:0] v);
    syn_event_t ev;
    ev.command = cmd;
    ev.weight = w;
    ev.volt = v;
    queued_events.push_back(ev);
    events_queued++;
  endtask

  function automatic logic [IO_W-1:0] pick_reg_value();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [IO_W-1:0] random_volt();
    case ($urandom_range(9))
      0: return FIELD_MAX;
      1: return FIELD_MIN;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_noise(int n);
    repeat (n) push_event(1'($urandom), 16'($urandom), random_volt());
  endtask

  // mostly same-sign spike burst then a train of decay steps
  task automatic push_sequence();
    bit neg;
    logic signed [IO_W-1:0] w;
    neg = 1'($urandom);
    repeat ($urandom_range(16, 1)) begin
      if ($urandom_range(9) == 0) w = neg ? FIELD_MIN : FIELD_MAX;
      else if ($urandom_range(4) == 0) w = 16'($urandom);
      else w = neg ? -16'($urandom_range(32767)) : 16'($urandom_range(32767));
      push_event(CMD_SPIKE, w, random_volt());
    end
    repeat ($urandom_range(24)) push_event(CMD_TICK, 16'($urandom), random_volt());
  endtask

  initial begin : stimulus
    int target;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    push_event(CMD_SPIKE, FIELD_MAX, FIELD_MAX);
    push_event(CMD_TICK, '0, '0);
    push_event(CMD_SPIKE, FIELD_MIN, FIELD_MIN);
    wait_until_idle();

    apply_setting('1, '0, '1, '1, FIELD_MIN);
    write_reg(SPARE_SLOT, 16'($urandom));
    push_event(CMD_TICK, '0, '0);
    repeat (17) push_event(CMD_SPIKE, FIELD_MAX, FIELD_MAX);
    push_event(CMD_TICK, FIELD_MIN, FIELD_MAX);
    push_event(CMD_SPIKE, FIELD_MIN, FIELD_MIN);
    push_event(CMD_TICK, 16'($urandom), '0);
    wait_until_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_setting(dexp_syn_pkg::NORM_RESET, 16'hE666, 16'hFAE1, 16'h0100, '0);
        1: apply_setting('1, '1, '1, '1, FIELD_MAX);
        2: apply_setting(16'h0001, '0, '0, '1, FIELD_MIN);
        default: apply_setting(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                               pick_reg_value(), pick_reg_value());
      endcase
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin sender_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      target = events_queued + PHASE_EVENTS;
      if (p % 4 == 0) begin
        push_noise(30);
        holdoff_requests++;
      end
      while (events_queued < target) begin
        if ($urandom_range(4) == 0) push_noise($urandom_range(10, 1));
        else push_sequence();
        if ($urandom_range(5) == 0) wait_until_idle();
      end
      wait_until_idle();
    end

    if (predicted_outputs.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived",
                                predicted_outputs.size()));
    $display("Run covered %0d spike and %0d tick transactions, %0d register writes,",
             spikes_sent, ticks_sent, reg_writes);
    $display("with %0d saturated results and %0d mismatches.", saturated_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
